>>> rtl/core/assert_macros.svh
// assertion macros used by the top-level rtl file
// needs clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define APT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked a fixed number of cycles later
`define APT_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

>>> rtl/core/apt_pkg.sv
// shared types and constants of the affine point transform
// no dependencies
package apt_pkg;

  typedef enum logic [1:0] {
    OP_W2P_CLAMP = 2'd0,
    OP_W2P_WIDE  = 2'd1,
    OP_P2W       = 2'd2
  } opcode_e;

  localparam logic [2:0] REG_COEF_11 = 3'd0;
  localparam logic [2:0] REG_COEF_12 = 3'd1;
  localparam logic [2:0] REG_COEF_21 = 3'd2;
  localparam logic [2:0] REG_COEF_22 = 3'd3;
  localparam logic [2:0] REG_SHIFT_X = 3'd4;
  localparam logic [2:0] REG_SHIFT_Y = 3'd5;

  localparam int unsigned CLAMP_LIMIT = 32000;
  localparam int unsigned NUM_CELLS   = 31;
  localparam int unsigned REM_W       = 89;
  localparam int unsigned DEN_W       = 64;

  typedef struct packed {
    logic signed [31:0] c11;
    logic signed [31:0] c12;
    logic signed [31:0] c21;
    logic signed [31:0] c22;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } coef_t;

  typedef struct packed {
    logic             is_div;
    logic             sing;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic [31:0]      q_x;
    logic [31:0]      q_y;
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [DEN_W-1:0] den;
  } cell_word_t;

endpackage

>>> rtl/core/apt_front.sv
// front pipeline: operand setup, products, sums, rounding and limiting
// depends on apt_pkg
module apt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apt_pkg::coef_t      coef_i,
  input  logic                in_valid_i,
  input  logic [1:0]          opcode_i,
  input  logic signed [31:0]  world_x_i,
  input  logic signed [31:0]  world_y_i,
  input  logic signed [31:0]  paper_x_i,
  input  logic signed [31:0]  paper_y_i,
  output logic                out_valid_o,
  output apt_pkg::cell_word_t out_word_o
);

  localparam logic signed [43:0] LimHi = 44'(apt_pkg::CLAMP_LIMIT);
  localparam logic signed [43:0] LimLo = -LimHi;
  localparam logic signed [43:0] SatHi = 44'sd2147483647;
  localparam logic signed [43:0] SatLo = -44'sd2147483648;
  localparam logic signed [66:0] RoundBias = 67'sd16777215;

  function automatic logic [31:0] limit(input logic signed [43:0] v, input logic clamp);
    logic signed [43:0] r;
    if (clamp) begin
      r = (v > LimHi) ? LimHi : ((v < LimLo) ? LimLo : v);
    end else begin
      r = (v > SatHi) ? SatHi : ((v < SatLo) ? SatLo : v);
    end
    return r[31:0];
  endfunction

  // stage 1: operands
  logic               v1_q;
  logic [1:0]         op1_q;
  logic signed [33:0] a1_q, b1_q;
  logic               fwd_in;
  logic signed [33:0] a_d, b_d;

  assign fwd_in = (opcode_i == apt_pkg::OP_W2P_CLAMP) || (opcode_i == apt_pkg::OP_W2P_WIDE);
  assign a_d = fwd_in ? 34'(world_x_i) : (34'(paper_x_i) - 34'(coef_i.dx));
  assign b_d = fwd_in ? 34'(world_y_i) : (34'sd0 - 34'(paper_y_i) - 34'(coef_i.dy));

  // stage 2: products
  logic               v2_q;
  logic [1:0]         op2_q;
  logic signed [65:0] m0_q, m1_q, m2_q, m3_q;
  logic signed [63:0] d0_q, d1_q;
  logic               fwd1;
  assign fwd1 = (op1_q == apt_pkg::OP_W2P_CLAMP) || (op1_q == apt_pkg::OP_W2P_WIDE);

  // stage 3: sums and determinant
  logic               v3_q;
  logic [1:0]         op3_q;
  logic signed [66:0] sx3_q, sy3_q;
  logic signed [64:0] det3_q;
  logic               fwd2;
  assign fwd2 = (op2_q == apt_pkg::OP_W2P_CLAMP) || (op2_q == apt_pkg::OP_W2P_WIDE);

  // stage 4: truncation toward zero and magnitudes
  logic               v4_q;
  logic [1:0]         op4_q;
  logic signed [42:0] tx4_q, ty4_q;
  logic [64:0]        magx4_q, magy4_q;
  logic [63:0]        magd4_q;
  logic               negx4_q, negy4_q, sing4_q;
  logic signed [66:0] sx_adj, sy_adj, sx_neg, sy_neg;
  logic signed [64:0] det_neg;

  assign sx_adj  = sx3_q + (sx3_q[66] ? RoundBias : 67'sd0);
  assign sy_adj  = sy3_q + (sy3_q[66] ? RoundBias : 67'sd0);
  assign sx_neg  = 67'sd0 - sx3_q;
  assign sy_neg  = 67'sd0 - sy3_q;
  assign det_neg = 65'sd0 - det3_q;

  // stage 5: final forward value, overflow test for division
  logic               v5_q;
  apt_pkg::cell_word_t w5_q, w5_d;
  logic signed [43:0] px5, py5;

  assign px5 = 44'(tx4_q) + 44'(coef_i.dx);
  assign py5 = 44'sd0 - 44'(ty4_q) - 44'(coef_i.dy);

  always_comb begin
    w5_d        = '0;
    w5_d.is_div = (op4_q == apt_pkg::OP_P2W);
    w5_d.sing   = (op4_q == apt_pkg::OP_P2W) && sing4_q;
    w5_d.neg_x  = negx4_q;
    w5_d.neg_y  = negy4_q;
    w5_d.ovf_x  = {6'd0, magx4_q} >= {magd4_q, 7'd0};
    w5_d.ovf_y  = {6'd0, magy4_q} >= {magd4_q, 7'd0};
    w5_d.rem_x  = {magx4_q, 24'd0};
    w5_d.rem_y  = {magy4_q, 24'd0};
    w5_d.den    = magd4_q;
    case (op4_q)
      apt_pkg::OP_W2P_CLAMP: begin
        w5_d.q_x = limit(px5, 1'b1);
        w5_d.q_y = limit(py5, 1'b1);
      end
      apt_pkg::OP_W2P_WIDE: begin
        w5_d.q_x = limit(px5, 1'b0);
        w5_d.q_y = limit(py5, 1'b0);
      end
      default: begin
        w5_d.q_x = '0;
        w5_d.q_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= opcode_i;
    a1_q   <= a_d;
    b1_q   <= b_d;
    op2_q  <= op1_q;
    m0_q   <= 66'(fwd1 ? a1_q : b1_q) * 66'(fwd1 ? coef_i.c11 : coef_i.c12);
    m1_q   <= 66'(fwd1 ? b1_q : a1_q) * 66'(fwd1 ? coef_i.c12 : coef_i.c22);
    m2_q   <= 66'(a1_q) * 66'(coef_i.c21);
    m3_q   <= 66'(b1_q) * 66'(fwd1 ? coef_i.c22 : coef_i.c11);
    d0_q   <= 64'(coef_i.c12) * 64'(coef_i.c21);
    d1_q   <= 64'(coef_i.c11) * 64'(coef_i.c22);
    op3_q  <= op2_q;
    sx3_q  <= fwd2 ? (67'(m0_q) + 67'(m1_q)) : (67'(m0_q) - 67'(m1_q));
    sy3_q  <= fwd2 ? (67'(m2_q) + 67'(m3_q)) : (67'(m2_q) - 67'(m3_q));
    det3_q <= 65'(d0_q) - 65'(d1_q);
    op4_q   <= op3_q;
    tx4_q   <= sx_adj[66:24];
    ty4_q   <= sy_adj[66:24];
    magx4_q <= sx3_q[66] ? sx_neg[64:0] : sx3_q[64:0];
    magy4_q <= sy3_q[66] ? sy_neg[64:0] : sy3_q[64:0];
    magd4_q <= det3_q[64] ? det_neg[63:0] : det3_q[63:0];
    negx4_q <= sx3_q[66] ^ det3_q[64];
    negy4_q <= sy3_q[66] ^ det3_q[64];
    sing4_q <= (det3_q == 65'sd0);
    w5_q    <= w5_d;
  end

  assign out_valid_o = v5_q;
  assign out_word_o  = w5_q;

endmodule

>>> rtl/core/apt_div_cell.sv
// one restoring division cell: one quotient bit for each axis
// depends on apt_pkg
module apt_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  apt_pkg::cell_word_t in_word_i,
  output logic                out_valid_o,
  output apt_pkg::cell_word_t out_word_o
);

  localparam int unsigned CmpW = apt_pkg::DEN_W + apt_pkg::NUM_CELLS;

  logic [CmpW-1:0] dsh, rx, ry, dx_diff, dy_diff;
  apt_pkg::cell_word_t word_d, word_q;
  logic valid_q;

  assign dsh     = CmpW'(in_word_i.den) << SHIFT;
  assign rx      = CmpW'(in_word_i.rem_x);
  assign ry      = CmpW'(in_word_i.rem_y);
  assign dx_diff = rx - dsh;
  assign dy_diff = ry - dsh;

  always_comb begin
    word_d = in_word_i;
    if (in_word_i.is_div && (rx >= dsh)) begin
      word_d.rem_x      = dx_diff[apt_pkg::REM_W-1:0];
      word_d.q_x[SHIFT] = 1'b1;
    end
    if (in_word_i.is_div && (ry >= dsh)) begin
      word_d.rem_y      = dy_diff[apt_pkg::REM_W-1:0];
      word_d.q_y[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

>>> rtl/core/affine_point_transform_unit.sv
// top level of the affine point transform: config registers, front, divider chain
// depends on apt_pkg, apt_front, apt_div_cell and assert_macros.svh
//
//  channel   direction  handshake                 word
//  command   in         start_i, busy_o           opcode_i, world_x/y_i, paper_x/y_i
//  config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//  result    out        done_o (one cycle)        out_x_o, out_y_o, singular_o
//
// one word is taken every cycle; each result passes through
// five front stages, 31 division cells and one output register
// in that order; the divider chain yields one quotient bit per cell
// reset sets the diagonal coefficients to 65536, clears the rest and drops all valid bits
// busy_o stays low and cfg_ready_o stays high; results cannot be stalled
`include "assert_macros.svh"

module affine_point_transform_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] world_x_i,
  input  logic signed [31:0] world_y_i,
  input  logic signed [31:0] paper_x_i,
  input  logic signed [31:0] paper_y_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               singular_o
);

  localparam int unsigned Latency = 5 + apt_pkg::NUM_CELLS + 1;
  localparam logic [31:0] SatMax = 32'h7fff_ffff;
  localparam logic [31:0] SatMin = 32'h8000_0000;

  // pipeline never pushes back
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // config registers, diagonal 65536 and all else zero after reset
  apt_pkg::coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.c11 <= 32'sd65536;
      coef_q.c12 <= '0;
      coef_q.c21 <= '0;
      coef_q.c22 <= 32'sd65536;
      coef_q.dx  <= '0;
      coef_q.dy  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        apt_pkg::REG_COEF_11: coef_q.c11 <= cfg_data_i;
        apt_pkg::REG_COEF_12: coef_q.c12 <= cfg_data_i;
        apt_pkg::REG_COEF_21: coef_q.c21 <= cfg_data_i;
        apt_pkg::REG_COEF_22: coef_q.c22 <= cfg_data_i;
        apt_pkg::REG_SHIFT_X: coef_q.dx  <= cfg_data_i;
        apt_pkg::REG_SHIFT_Y: coef_q.dy  <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // chain taps: index 0 is the front output, last is after all cells
  apt_pkg::cell_word_t chain_w [apt_pkg::NUM_CELLS+1];
  logic                chain_v [apt_pkg::NUM_CELLS+1];

  apt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .in_valid_i  (start_i && !busy_o),
    .opcode_i    (opcode_i),
    .world_x_i   (world_x_i),
    .world_y_i   (world_y_i),
    .paper_x_i   (paper_x_i),
    .paper_y_i   (paper_y_i),
    .out_valid_o (chain_v[0]),
    .out_word_o  (chain_w[0])
  );

  // quotient bits from msb (bit 30) down to bit 0
  for (genvar g = 0; g < apt_pkg::NUM_CELLS; g++) begin : g_cell
    apt_div_cell #(
      .SHIFT(apt_pkg::NUM_CELLS - 1 - g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_v[g]),
      .in_word_i   (chain_w[g]),
      .out_valid_o (chain_v[g+1]),
      .out_word_o  (chain_w[g+1])
    );
  end

  // output stage: sign, saturation and singular handling
  apt_pkg::cell_word_t last_w;
  logic [31:0] res_x_d, res_y_d;
  logic        done_q, sing_q;
  logic [31:0] res_x_q, res_y_q;

  assign last_w = chain_w[apt_pkg::NUM_CELLS];

  always_comb begin
    res_x_d = last_w.q_x;
    res_y_d = last_w.q_y;
    if (last_w.is_div) begin
      if (last_w.sing) begin
        res_x_d = '0;
        res_y_d = '0;
      end else begin
        if (last_w.ovf_x) res_x_d = last_w.neg_x ? SatMin : SatMax;
        else if (last_w.neg_x) res_x_d = 32'd0 - last_w.q_x;
        if (last_w.ovf_y) res_y_d = last_w.neg_y ? SatMin : SatMax;
        else if (last_w.neg_y) res_y_d = 32'd0 - last_w.q_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_v[apt_pkg::NUM_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    res_x_q <= res_x_d;
    res_y_q <= res_y_d;
    sing_q  <= last_w.is_div && last_w.sing;
  end

  assign done_o     = done_q;
  assign out_x_o    = res_x_q;
  assign out_y_o    = res_y_q;
  assign singular_o = sing_q;

  // checks
  `APT_ASSERT_DELAY(a_fixed_latency, start_i && !busy_o, Latency, done_o, "result missing after start")
  `APT_ASSERT_IMPL(a_singular_zero, done_o && singular_o, (out_x_o == 32'd0) && (out_y_o == 32'd0), "singular result not zero")

endmodule

>>> tb/sv/affine_point_transform_unit_tb.sv
// self-checking testbench of the affine point transform unit
// depends on apt_pkg and the rtl of affine_point_transform_unit
module affine_point_transform_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one command word and one result word
  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } point_cmd_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               sing;
  } point_res_t;

  localparam logic signed [127:0] Q_SCALE  = 128'sd16777216;
  localparam logic signed [127:0] CLAMP_HI = apt_pkg::CLAMP_LIMIT;
  localparam logic signed [127:0] CLAMP_LO = -CLAMP_HI;
  localparam logic signed [127:0] S32_MAX  = 128'sd2147483647;
  localparam logic signed [127:0] S32_MIN  = -128'sd2147483648;
  localparam int unsigned         DRAIN_CYCLES = 48;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start_i     = 1'b0;
  logic               busy_o;
  logic [1:0]         opcode_i    = '0;
  logic signed [31:0] world_x_i   = '0;
  logic signed [31:0] world_y_i   = '0;
  logic signed [31:0] paper_x_i   = '0;
  logic signed [31:0] paper_y_i   = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i  = '0;
  logic               done_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic               singular_o;

  affine_point_transform_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i,
    .world_x_i, .world_y_i, .paper_x_i, .paper_y_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .out_x_o, .out_y_o, .singular_o
  );

  // shadow copy of the matrix and translation
  logic signed [31:0] m11 = 32'sd65536, m12 = '0, m21 = '0, m22 = 32'sd65536;
  logic signed [31:0] tr_x = '0, tr_y = '0;

  point_cmd_t cmd_q[$];       // words waiting for the driver
  point_res_t point_q[$];     // predicted points, oldest first
  point_cmd_t cur_cmd;        // word on the command port
  int unsigned gap_left = 0;
  int unsigned nxt_gap;
  bit          gaps_on = 1'b0;
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned op_seen[4] = '{default: 0};
  int unsigned n_writes = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #2ms;
    $display("affine_point_transform_unit_tb: done, errors");
    $finish;
  end

  function automatic logic signed [127:0] wide(input logic signed [63:0] v);
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
    if (v > S32_MAX) return S32_MAX[31:0];
    if (v < S32_MIN) return S32_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_paper(input logic signed [127:0] v);
    if (v > CLAMP_HI) return CLAMP_HI[31:0];
    if (v < CLAMP_LO) return CLAMP_LO[31:0];
    return v[31:0];
  endfunction

  // expected point for one command under the current shadow registers
  function automatic point_res_t transform_point(input point_cmd_t c);
    point_res_t r;
    logic signed [127:0] sx, sy, dx, dy, ex, ey, det;
    r = '{x: '0, y: '0, sing: 1'b0};
    case (apt_pkg::opcode_e'(c.op))
      apt_pkg::OP_W2P_CLAMP, apt_pkg::OP_W2P_WIDE: begin
        sx = wide(c.wx) * wide(m11) + wide(c.wy) * wide(m12);
        sy = wide(c.wx) * wide(m21) + wide(c.wy) * wide(m22);
        // signed division truncates toward zero
        ex = sx / Q_SCALE + wide(tr_x);
        ey = -(sy / Q_SCALE) - wide(tr_y);
        if (apt_pkg::opcode_e'(c.op) == apt_pkg::OP_W2P_CLAMP) begin
          r.x = clamp_paper(ex);
          r.y = clamp_paper(ey);
        end else begin
          r.x = sat32(ex);
          r.y = sat32(ey);
        end
      end
      apt_pkg::OP_P2W: begin
        dx  = wide(c.px) - wide(tr_x);
        dy  = -wide(c.py) - wide(tr_y);
        det = wide(m12) * wide(m21) - wide(m11) * wide(m22);
        if (det == 0) begin
          r.sing = 1'b1;
        end else begin
          ex  = (dy * wide(m12) - dx * wide(m22)) * Q_SCALE / det;
          ey  = (dx * wide(m21) - dy * wide(m11)) * Q_SCALE / det;
          r.x = sat32(ex);
          r.y = sat32(ey);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  // random gap before the next word, none while gaps are off
  function automatic int unsigned draw_gap();
    return gaps_on ? $urandom_range(0, 11) : 0;
  endfunction

  task automatic drive_next();
    cur_cmd = cmd_q.pop_front();
    start_i   <= 1'b1;
    opcode_i  <= cur_cmd.op;
    world_x_i <= cur_cmd.wx;
    world_y_i <= cur_cmd.wy;
    paper_x_i <= cur_cmd.px;
    paper_y_i <= cur_cmd.py;
  endtask

  // driver: a word is taken when start is high and busy is low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      gap_left <= 0;
    end else if (start_i && !busy_o) begin
      point_q.push_back(transform_point(cur_cmd));
      op_seen[cur_cmd.op]++;
      nxt_gap = draw_gap();
      if (nxt_gap == 0 && cmd_q.size() != 0) begin
        drive_next();
      end else begin
        start_i  <= 1'b0;
        gap_left <= nxt_gap;
      end
    end else if (!start_i) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() != 0) begin
        drive_next();
      end
    end
  end

  // monitor: each done pulse carries one word
  always @(posedge clk_i) begin
    point_res_t exp_r;
    if (rst_ni && done_o) begin
      if (point_q.size() == 0) begin
        report("unexpected result", out_x_o, '0);
      end else begin
        exp_r = point_q.pop_front();
        checked++;
        if (out_x_o !== exp_r.x) report("out_x", out_x_o, exp_r.x);
        if (out_y_o !== exp_r.y) report("out_y", out_y_o, exp_r.y);
        if (singular_o !== exp_r.sing) report("singular", 32'(singular_o), 32'(exp_r.sing));
      end
    end
  end

  // random value mixing full range, small magnitudes and corner values
  function automatic logic signed [31:0] rand_word(input int unsigned small_span);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 4) return $urandom;
    if (mode < 8) return $signed($urandom_range(0, 2 * small_span)) - $signed(small_span);
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return 32'sd1 <<< $urandom_range(0, 31);
    endcase
  endfunction

  function automatic point_cmd_t rand_cmd();
    point_cmd_t c;
    // opcode 3 is rare, it only produces zeros
    c.op = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    c.wx = rand_word(1 << 24);
    c.wy = rand_word(1 << 24);
    c.px = rand_word(1 << 16);
    c.py = rand_word(1 << 16);
    return c;
  endfunction

  function automatic point_cmd_t mk(input apt_pkg::opcode_e op, input logic signed [31:0] a,
                                    input logic signed [31:0] b);
    point_cmd_t c;
    c.op = op;
    c.wx = a;
    c.wy = b;
    c.px = a;
    c.py = b;
    return c;
  endfunction

  // register write, valid is left high for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_writes++;
    case (idx)
      apt_pkg::REG_COEF_11: m11 = val;
      apt_pkg::REG_COEF_12: m12 = val;
      apt_pkg::REG_COEF_21: m21 = val;
      apt_pkg::REG_COEF_22: m22 = val;
      apt_pkg::REG_SHIFT_X: tr_x = val;
      apt_pkg::REG_SHIFT_Y: tr_y = val;
      default: ;   // indexes past the shift registers are ignored
    endcase
  endtask

  task automatic load_regs(input logic [31:0] v[6]);
    for (int i = 0; i < 6; i++) write_reg(3'(i), v[i]);
  endtask

  // wait until every word is out, then let the pipeline drain
  task automatic wait_idle();
    while (cmd_q.size() != 0 || start_i || point_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n);
    gaps_on = $urandom_range(0, 3) != 0;
    for (int i = 0; i < n; i++) cmd_q.push_back(rand_cmd());
    wait_idle();
  endtask

  initial begin
    logic [31:0] v[6];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset map (diagonal 65536, a scale of 1/256): corner words, clamp edges on both axes
    cmd_q.push_back(mk(apt_pkg::OP_W2P_CLAMP, 0, 0));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_CLAMP, 32'h7fffffff, 32'h7fffffff));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_CLAMP, 32'h80000000, 32'h80000000));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_CLAMP, 32000 * 256, -32000 * 256));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_CLAMP, 32001 * 256, -32001 * 256));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_CLAMP, -32001 * 256, 32001 * 256));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_CLAMP, -32000 * 256, 32000 * 256));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_CLAMP, 20, 40000 * 256));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_CLAMP, -255, 255));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_WIDE, 32'h7fffffff, 32'h80000000));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_WIDE, 32'h80000000, 32'h7fffffff));
    cmd_q.push_back(mk(apt_pkg::OP_W2P_WIDE, -1, 1));
    cmd_q.push_back(mk(apt_pkg::OP_P2W, 0, 0));
    cmd_q.push_back(mk(apt_pkg::OP_P2W, 32'h7fffffff, 32'h80000000));
    cmd_q.push_back(mk(apt_pkg::OP_P2W, 32'h80000000, 32'h7fffffff));
    cmd_q.push_back(mk(apt_pkg::OP_P2W, 1, -1));
    cmd_q.push_back(mk(apt_pkg::opcode_e'(2'd3), 32'h7fffffff, -1));
    cmd_q.push_back(mk(apt_pkg::opcode_e'(2'd3), 0, 0));
    wait_idle();
    run_random(130);

    // largest coefficients (c22 one below), lowest shifts, writes past the last register
    @(posedge clk_i);
    v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7ffffffe, 32'h80000000, 32'h80000000};
    load_regs(v);
    write_reg(3'd6, 32'hffffffff);
    write_reg(3'd7, 32'h12345678);
    cfg_valid_i <= 1'b0;
    run_random(130);

    // lowest coefficients but c12 at its largest, highest shifts
    @(posedge clk_i);
    v = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
    load_regs(v);
    cfg_valid_i <= 1'b0;
    run_random(130);

    // zero determinant: every inverse reports singular
    @(posedge clk_i);
    v = '{32'h00020000, 32'h00010000, 32'h00040000, 32'h00020000, 32'd7, -32'sd3};
    load_regs(v);
    cfg_valid_i <= 1'b0;
    cmd_q.push_back(mk(apt_pkg::OP_P2W, 100, -100));
    run_random(100);

    // all-zero matrix
    @(posedge clk_i);
    v = '{0, 0, 0, 0, 0, 0};
    load_regs(v);
    cfg_valid_i <= 1'b0;
    run_random(40);

    // random settings, coefficients mixing full range, magnitudes up to 2^18 and corner values
    for (int p = 0; p < 5; p++) begin
      @(posedge clk_i);
      for (int i = 0; i < 4; i++) v[i] = rand_word(1 << 18);
      v[4] = rand_word(1 << 15);
      v[5] = rand_word(1 << 15);
      load_regs(v);
      cfg_valid_i <= 1'b0;
      run_random(110);
    end

    $display("covered %0d clamped, %0d wide, %0d inverse, %0d unused-opcode words",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("%0d results checked across %0d register writes", checked, n_writes);
    if (errors == 0) begin
      $display("affine_point_transform_unit_tb: done, clean");
    end else begin
      $display("affine_point_transform_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
